/* hdl/rsb_pkg.sv */
// Shared constants, word types and the quarter-wave sine table for the rotated sprite blitter.
// Depends on nothing; every other file in hdl/ imports it.
package rsb_pkg;

    // Geometry and storage sizes
    localparam int SCALE      = 2;
    localparam int SCREEN_W   = 512;
    localparam int SCREEN_H   = 512;
    localparam int SHEET_SIZE = 256;

    // Screen sizes are powers of two, so wrapping is a truncation to these widths
    localparam int XW = $clog2(SCREEN_W);
    localparam int YW = $clog2(SCREEN_H);
    localparam int SHEET_BITS = $clog2(SHEET_SIZE);
    localparam int ADDR_W = 1 + 2 * SHEET_BITS;

    // Fixed-point layout: Q1.14 trig, scaled offsets, products and sums
    localparam int Q14_FRAC = 14;
    localparam int TRIG_W = 16;
    localparam int DX_W = 8 + $clog2(SCALE);
    localparam int PW = TRIG_W + DX_W;
    localparam int SW = PW + 2;

    // Write counter width for the SCALE x SCALE block
    localparam int CW = (SCALE > 1) ? $clog2(SCALE) : 1;

    // Named codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;
    localparam logic [23:0] BLACK = 24'h000000;
    localparam int QUARTER_TURN = 90;
    localparam int HALF_TURN = 180;
    localparam int THREE_QUARTER_TURN = 270;
    localparam int FULL_TURN = 360;

    // Input word
    typedef struct packed {
        logic        action;
        logic        sheet;
        logic [7:0]  tex_x;
        logic [7:0]  tex_y;
        logic [23:0] texel_color;
        logic [8:0]  center_x;
        logic [8:0]  center_y;
        logic [8:0]  angle;
        logic [5:0]  pixel_col;
        logic [5:0]  pixel_row;
        logic [6:0]  sprite_width;
        logic [6:0]  sprite_height;
    } cmd_word_t;

    // Output word
    typedef struct packed {
        logic [XW-1:0] write_x;
        logic [YW-1:0] write_y;
        logic [23:0]   pixel_color;
        logic          last_write;
    } wr_word_t;

    // Geometry leaving the lookup stage
    typedef struct packed {
        logic                     draw;
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [DX_W-1:0]   dx;
        logic signed [DX_W-1:0]   dy;
        logic [8:0]               cx;
        logic [8:0]               cy;
    } geo_word_t;

    // Top-left write position and color of one visible pixel
    typedef struct packed {
        logic [XW-1:0] base_x;
        logic [YW-1:0] base_y;
        logic [23:0]   color;
    } pos_word_t;

    // round(16384 * sin(deg)) for 0..90 degrees
    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // Q1.14 sine of an angle already reduced to 0..359
    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [8:0] deg);
        logic [6:0]        idx;
        logic              neg;
        logic [TRIG_W-1:0] mag;
        if (deg <= 9'(QUARTER_TURN)) begin
            idx = deg[6:0];
            neg = 1'b0;
        end else if (deg <= 9'(HALF_TURN)) begin
            idx = 7'(9'(HALF_TURN) - deg);
            neg = 1'b0;
        end else if (deg <= 9'(THREE_QUARTER_TURN)) begin
            idx = 7'(deg - 9'(HALF_TURN));
            neg = 1'b1;
        end else begin
            idx = 7'(9'(FULL_TURN) - deg);
            neg = 1'b1;
        end
        mag = {1'b0, QUARTER_SINE[idx]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

/* hdl/rsb_front.sv */
// Front stage of the blitter: texel sheet memory, angle reduction and sine lookup, offsets.
// Depends on rsb_pkg.
module rsb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  rsb_pkg::cmd_word_t cmd,
    output logic               geo_valid,
    input  logic               geo_stall,
    output rsb_pkg::geo_word_t geo,
    output logic [23:0]        texel
);
    import rsb_pkg::*;

    logic [23:0]       sheet_mem [0:(1 << ADDR_W) - 1];
    logic [23:0]       rdata_reg;
    logic              valid_reg;
    geo_word_t         geo_reg;
    geo_word_t         geo_next;
    logic              accept;
    logic [ADDR_W-1:0] addr;
    logic [SHEET_BITS-1:0] col;
    logic [SHEET_BITS-1:0] row;
    logic [8:0]        ang;
    logic [9:0]        cos_sum;
    logic [8:0]        cos_ang;
    logic signed [7:0] diff_x;
    logic signed [7:0] diff_y;
    logic signed [DX_W-1:0] scale_s;

    // Take a new word whenever the stage register is empty or moving on
    assign cmd_stall = valid_reg && geo_stall;
    assign accept    = cmd_valid && !cmd_stall;

    // Form the sheet address; a draw offsets into the sprite, wrapping in the sheet
    always_comb
    begin
        if (cmd.action == ACT_DRAW)
        begin
            col = SHEET_BITS'(cmd.tex_x) + SHEET_BITS'(cmd.pixel_col);
            row = SHEET_BITS'(cmd.tex_y) + SHEET_BITS'(cmd.pixel_row);
        end
        else
        begin
            col = SHEET_BITS'(cmd.tex_x);
            row = SHEET_BITS'(cmd.tex_y);
        end
        addr = {cmd.sheet, row, col};
    end

    // Reduce the angle, look up sine and cosine, and form the scaled offsets
    always_comb
    begin
        ang     = (cmd.angle >= 9'(FULL_TURN)) ? cmd.angle - 9'(FULL_TURN) : cmd.angle;
        cos_sum = {1'b0, ang} + 10'(QUARTER_TURN);
        cos_ang = (cos_sum >= 10'(FULL_TURN)) ? 9'(cos_sum - 10'(FULL_TURN)) : cos_sum[8:0];
        diff_x  = $signed({2'b00, cmd.pixel_col}) - $signed({2'b00, cmd.sprite_width[6:1]});
        diff_y  = $signed({2'b00, cmd.pixel_row}) - $signed({2'b00, cmd.sprite_height[6:1]});
        scale_s = DX_W'(SCALE);

        geo_next.draw  = (cmd.action == ACT_DRAW);
        geo_next.sin_q = sine_q14(ang);
        geo_next.cos_q = sine_q14(cos_ang);
        geo_next.dx    = DX_W'(diff_x) * scale_s;
        geo_next.dy    = DX_W'(diff_y) * scale_s;
        geo_next.cx    = cmd.center_x;
        geo_next.cy    = cmd.center_y;
    end

    // Write a loaded texel, read the texel of a draw
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cmd.action == ACT_LOAD)
            begin
                sheet_mem[addr] <= cmd.texel_color;
            end
            rdata_reg <= sheet_mem[addr];
        end
    end

    // Hold the geometry alongside the read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            geo_reg <= geo_next;
        end
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            valid_reg <= cmd_valid;
        end
    end

    assign geo_valid = valid_reg;
    assign geo       = geo_reg;
    assign texel     = rdata_reg;

endmodule

/* hdl/rsb_rotate.sv */
// Rotation datapath: drop black or load words, multiply by sine and cosine, sum, truncate.
// Depends on rsb_pkg.
module rsb_rotate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               geo_valid,
    output logic               geo_stall,
    input  rsb_pkg::geo_word_t geo,
    input  logic [23:0]        texel,
    output logic               pos_valid,
    input  logic               pos_stall,
    output rsb_pkg::pos_word_t pos
);
    import rsb_pkg::*;

    // Product stage
    logic                 v2_reg;
    logic signed [PW-1:0] cdx_reg;
    logic signed [PW-1:0] sdy_reg;
    logic signed [PW-1:0] sdx_reg;
    logic signed [PW-1:0] cdy_reg;
    logic [8:0]           cx2_reg;
    logic [8:0]           cy2_reg;
    logic [23:0]          color2_reg;

    // Sum stage
    logic                 v3_reg;
    logic signed [SW-1:0] sum_x_reg;
    logic signed [SW-1:0] sum_y_reg;
    logic signed [SW-1:0] sum_x_next;
    logic signed [SW-1:0] sum_y_next;
    logic [23:0]          color3_reg;

    // Position stage
    logic                 v4_reg;
    pos_word_t            pos_reg;
    pos_word_t            pos_next;
    logic signed [SW-1:0] q_x;
    logic signed [SW-1:0] q_y;
    logic                 adj_x;
    logic                 adj_y;

    logic adv2;
    logic adv3;
    logic adv4;

    // A stage loads when it is empty or its word moves on
    assign adv4      = !v4_reg || !pos_stall;
    assign adv3      = !v3_reg || adv4;
    assign adv2      = !v2_reg || adv3;
    assign geo_stall = !adv2;

    // Center in Q14 plus the rotated offset
    always_comb
    begin
        sum_x_next = (SW'($signed({1'b0, cx2_reg})) <<< Q14_FRAC)
                   + SW'(cdx_reg) - SW'(sdy_reg);
        sum_y_next = (SW'($signed({1'b0, cy2_reg})) <<< Q14_FRAC)
                   + SW'(sdx_reg) + SW'(cdy_reg);
    end

    // Truncate toward zero, then step back by half the block and wrap into the screen
    always_comb
    begin
        q_x   = sum_x_reg >>> Q14_FRAC;
        q_y   = sum_y_reg >>> Q14_FRAC;
        adj_x = sum_x_reg[SW-1] && (sum_x_reg[Q14_FRAC-1:0] != '0);
        adj_y = sum_y_reg[SW-1] && (sum_y_reg[Q14_FRAC-1:0] != '0);
        pos_next.base_x = XW'(q_x) + XW'(adj_x) - XW'(SCALE / 2);
        pos_next.base_y = YW'(q_y) + YW'(adj_y) - YW'(SCALE / 2);
        pos_next.color  = color3_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            cdx_reg    <= PW'(geo.cos_q) * PW'(geo.dx);
            sdy_reg    <= PW'(geo.sin_q) * PW'(geo.dy);
            sdx_reg    <= PW'(geo.sin_q) * PW'(geo.dx);
            cdy_reg    <= PW'(geo.cos_q) * PW'(geo.dy);
            cx2_reg    <= geo.cx;
            cy2_reg    <= geo.cy;
            color2_reg <= texel;
        end
        if (adv3)
        begin
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            color3_reg <= color2_reg;
        end
        if (adv4)
        begin
            pos_reg <= pos_next;
        end
    end

    // Valid bits; drop loads and black texels at the product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
            begin
                v2_reg <= geo_valid && geo.draw && (texel != BLACK);
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign pos_valid = v4_reg;
    assign pos       = pos_reg;

endmodule

/* hdl/rsb_expand.sv */
// Expands one visible pixel into SCALE x SCALE screen writes through an output register.
// Depends on rsb_pkg.
module rsb_expand (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pos_valid,
    output logic               pos_stall,
    input  rsb_pkg::pos_word_t pos,
    output logic               wr_valid,
    input  logic               wr_stall,
    output rsb_pkg::wr_word_t  wr
);
    import rsb_pkg::*;

    logic            cur_valid_reg;
    pos_word_t       cur_reg;
    logic [CW-1:0]   xx_reg;
    logic [CW-1:0]   yy_reg;
    logic            wr_valid_reg;
    wr_word_t        wr_reg;
    wr_word_t        wr_next;
    logic            emit;
    logic            last;

    // Produce a write whenever the output register is free or being taken
    assign emit      = cur_valid_reg && (!wr_valid_reg || !wr_stall);
    assign last      = (xx_reg == CW'(SCALE - 1)) && (yy_reg == CW'(SCALE - 1));
    assign pos_stall = cur_valid_reg && !(emit && last);

    // Offset the write inside the block; x is the outer count, y the inner
    always_comb
    begin
        wr_next.write_x     = cur_reg.base_x + XW'(xx_reg);
        wr_next.write_y     = cur_reg.base_y + YW'(yy_reg);
        wr_next.pixel_color = cur_reg.color;
        wr_next.last_write  = last;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!pos_stall)
        begin
            cur_reg <= pos;
        end
        if (emit)
        begin
            wr_reg <= wr_next;
        end
    end

    // Control: current pixel, write counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            xx_reg        <= '0;
            yy_reg        <= '0;
            wr_valid_reg  <= 1'b0;
        end
        else
        begin
            // Step through the block
            if (emit && !last)
            begin
                if (yy_reg == CW'(SCALE - 1))
                begin
                    yy_reg <= '0;
                    xx_reg <= xx_reg + CW'(1);
                end
                else
                begin
                    yy_reg <= yy_reg + CW'(1);
                end
            end
            // Take the next pixel once the current one is done
            if (!pos_stall)
            begin
                cur_valid_reg <= pos_valid;
                xx_reg        <= '0;
                yy_reg        <= '0;
            end
            // Hold the output word until taken
            if (emit)
            begin
                wr_valid_reg <= 1'b1;
            end
            else if (!wr_stall)
            begin
                wr_valid_reg <= 1'b0;
            end
        end
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

endmodule

/* hdl/rotated_sprite_blit.sv */
// Rotated sprite blitter: texel load, rotate about a screen center, scaled block of writes.
// First write of a visible pixel: front register, product, sum and position stages, then
// the expander's pixel and output registers. Throughput: one load or black-pixel word per
// cycle and SCALE*SCALE (4) writes per visible pixel, one per cycle, both while not stalled.
// Reset clears all valid bits and counters; sheet contents stay undefined until loaded.
// Depends on rsb_pkg, rsb_front, rsb_rotate, rsb_expand.
module rotated_sprite_blit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  rsb_pkg::cmd_word_t cmd,
    output logic               wr_valid,
    input  logic               wr_stall,
    output rsb_pkg::wr_word_t  wr
);
    import rsb_pkg::*;

    logic        geo_valid;
    logic        geo_stall;
    geo_word_t   geo;
    logic [23:0] texel;
    logic        pos_valid;
    logic        pos_stall;
    pos_word_t   pos;

    // Sheet memory and trig lookup
    rsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .geo_valid (geo_valid),
        .geo_stall (geo_stall),
        .geo       (geo),
        .texel     (texel)
    );

    // Multiply, sum, truncate
    rsb_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .geo_valid (geo_valid),
        .geo_stall (geo_stall),
        .geo       (geo),
        .texel     (texel),
        .pos_valid (pos_valid),
        .pos_stall (pos_stall),
        .pos       (pos)
    );

    // Scaled block of screen writes
    rsb_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_valid (pos_valid),
        .pos_stall (pos_stall),
        .pos       (pos),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr        (wr)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rotated_sprite_blit: texel loads and pixel draws are predicted
// by a behavioral model of the sheets, the rotation and the scaled block of screen writes.
// Depends on rsb_pkg for the word types and geometry, and on the rotated_sprite_blit RTL.
module tb_top;
    import rsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int CMD_BITS       = $bits(cmd_word_t);
    localparam longint Q14_ONE    = 16384;

    // round(16384 * sin(deg)) for 0..90 degrees
    localparam int SINE_TABLE [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      wr_valid;
    logic      wr_stall  = 1'b0;
    wr_word_t  wr;

    // Driver and sink bookkeeping
    cmd_word_t cmd_backlog [$];
    logic      cmd_fired     = 1'b0;
    int        send_gap      = 0;
    int        stall_left    = 0;
    int        hold_left     = 0;
    int        hold_requests = 0;
    int        holds_served  = 0;
    bit        no_gaps       = 1'b0;

    // Model state and scoreboard
    logic [23:0] texel_model [int];
    wr_word_t    expected_writes [$];
    int          planned_texels [$];
    bit          planned_mark [int];

    int cmds_queued   = 0;
    int cmds_accepted = 0;
    int loads_seen    = 0;
    int draws_seen    = 0;
    int blank_draws   = 0;
    int writes_seen   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int sender_pauses = 0;

    rotated_sprite_blit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr        (wr)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Flat index of one texel: sheet, then row, then column
    function automatic int texel_addr(input logic sht, input logic [7:0] col,
                                      input logic [7:0] row);
        return int'({sht, row, col});
    endfunction

    function automatic longint sine_q14(input int deg);
        int d;
        d = deg % FULL_TURN;
        if (d <= QUARTER_TURN)
            return SINE_TABLE[d];
        else if (d <= HALF_TURN)
            return SINE_TABLE[HALF_TURN - d];
        else if (d <= THREE_QUARTER_TURN)
            return -SINE_TABLE[d - HALF_TURN];
        else
            return -SINE_TABLE[FULL_TURN - d];
    endfunction

    function automatic longint wrap_mod(input longint v, input longint size);
        longint m;
        m = v % size;
        if (m < 0)
            m = m + size;
        return m;
    endfunction

    // Most gaps are zero or short, a few are long; none while no_gaps is set
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] pick_color();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return BLACK;
        else if (r < 18)
            return 24'hFFFFFF;
        else if (r < 24)
            return 24'h1 << $urandom_range(0, 23);
        else
            return 24'($urandom_range(1, 24'hFFFFFF));
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        w = CMD_BITS'({$urandom, $urandom, $urandom});
        return w;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Work out the screen writes that one accepted command word causes
    task automatic model_command(input cmd_word_t c);
        int          addr;
        logic [23:0] color;
        longint      s, co, dx, dy, px, py, col, row, half_w, half_h;
        wr_word_t    w;
        if (c.action == ACT_LOAD)
        begin
            texel_model[texel_addr(c.sheet, c.tex_x, c.tex_y)] = c.texel_color;
            loads_seen++;
            return;
        end
        draws_seen++;
        addr = texel_addr(c.sheet, c.tex_x + c.pixel_col, c.tex_y + c.pixel_row);
        color = texel_model.exists(addr) ? texel_model[addr] : BLACK;
        if (color == BLACK)
        begin
            blank_draws++;
            return;
        end
        s  = sine_q14(int'(c.angle));
        co = sine_q14(int'(c.angle) + QUARTER_TURN);
        col    = c.pixel_col;
        row    = c.pixel_row;
        half_w = c.sprite_width / 2;
        half_h = c.sprite_height / 2;
        dx = (col - half_w) * SCALE;
        dy = (row - half_h) * SCALE;
        // Signed division truncates toward zero
        px = (longint'(c.center_x) * Q14_ONE + co * dx - s * dy) / Q14_ONE;
        py = (longint'(c.center_y) * Q14_ONE + s * dx + co * dy) / Q14_ONE;
        for (int xx = 0; xx < SCALE; xx++)
        begin
            for (int yy = 0; yy < SCALE; yy++)
            begin
                w.write_x     = XW'(wrap_mod(px + xx - SCALE / 2, SCREEN_W));
                w.write_y     = YW'(wrap_mod(py + yy - SCALE / 2, SCREEN_H));
                w.pixel_color = color;
                w.last_write  = (xx == SCALE - 1) && (yy == SCALE - 1);
                expected_writes.insert(expected_writes.size(), w);
            end
        end
    endtask

    task automatic check_write(input wr_word_t got);
        wr_word_t want;
        writes_seen++;
        if (expected_writes.size() == 0)
        begin
            report($sformatf("unexpected write x=%0d y=%0d color=%06h last=%0b",
                             got.write_x, got.write_y, got.pixel_color, got.last_write));
            return;
        end
        want = expected_writes.pop_front();
        if (got.write_x !== want.write_x || got.write_y !== want.write_y ||
            got.pixel_color !== want.pixel_color || got.last_write !== want.last_write)
            report($sformatf({"write mismatch: want x=%0d y=%0d color=%06h last=%0b, ",
                              "got x=%0d y=%0d color=%06h last=%0b"},
                             want.write_x, want.write_y, want.pixel_color, want.last_write,
                             got.write_x, got.write_y, got.pixel_color, got.last_write));
    endtask

    // Queue one word and note which texels will hold a value once it is taken
    task automatic queue_word(input cmd_word_t w);
        int a;
        if (w.action == ACT_LOAD)
        begin
            a = texel_addr(w.sheet, w.tex_x, w.tex_y);
            if (!planned_mark.exists(a))
            begin
                planned_mark[a] = 1'b1;
                planned_texels.insert(planned_texels.size(), a);
            end
        end
        cmd_backlog.insert(cmd_backlog.size(), w);
        cmds_queued++;
    endtask

    task automatic load_word(input logic sht, input logic [7:0] x, input logic [7:0] y,
                             input logic [23:0] color);
        cmd_word_t w;
        w = random_word();
        w.action      = ACT_LOAD;
        w.sheet       = sht;
        w.tex_x       = x;
        w.tex_y       = y;
        w.texel_color = color;
        queue_word(w);
    endtask

    task automatic draw_word(input logic sht, input logic [7:0] tx, input logic [7:0] ty,
                             input logic [5:0] pc, input logic [5:0] pr,
                             input logic [6:0] sw, input logic [6:0] sh,
                             input logic [8:0] cx, input logic [8:0] cy,
                             input logic [8:0] ang);
        cmd_word_t w;
        w = random_word();
        w.action        = ACT_DRAW;
        w.sheet         = sht;
        w.tex_x         = tx;
        w.tex_y         = ty;
        w.pixel_col     = pc;
        w.pixel_row     = pr;
        w.sprite_width  = sw;
        w.sprite_height = sh;
        w.center_x      = cx;
        w.center_y      = cy;
        w.angle         = ang;
        queue_word(w);
    endtask

    // Load a small sprite patch, then draw every pixel of it at one center and angle
    task automatic gen_sprite();
        int sw, sh, bx, by, cx, cy, ang;
        bit sht;
        sw  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        sh  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        bx  = $urandom_range(0, 255);
        by  = $urandom_range(0, 255);
        sht = 1'($urandom_range(0, 1));
        for (int r = 0; r < sh; r++)
            for (int c = 0; c < sw; c++)
                load_word(sht, 8'(bx + c), 8'(by + r), pick_color());
        cx  = $urandom_range(0, 511);
        cy  = $urandom_range(0, 511);
        ang = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
        for (int r = 0; r < sh; r++)
            for (int c = 0; c < sw; c++)
                draw_word(sht, 8'(bx), 8'(by), 6'(c), 6'(r), 7'(sw), 7'(sh),
                          9'(cx), 9'(cy), 9'(ang));
    endtask

    // Stray load anywhere, or a draw of some loaded texel with random geometry
    task automatic gen_noise();
        cmd_word_t w;
        int        a;
        w = random_word();
        if ($urandom_range(0, 99) < 40)
        begin
            w.action      = ACT_LOAD;
            w.texel_color = pick_color();
        end
        else
        begin
            a = planned_texels[$urandom_range(0, planned_texels.size() - 1)];
            w.action = ACT_DRAW;
            w.sheet  = a[16];
            w.tex_x  = a[7:0] - w.pixel_col;
            w.tex_y  = a[15:8] - w.pixel_row;
        end
        queue_word(w);
    endtask

    task automatic gen_random(input int target);
        while (cmds_queued < target)
        begin
            if ($urandom_range(0, 99) < 60)
                gen_sprite();
            else
                gen_noise();
        end
    endtask

    // Hold the sender until every queued word is taken and every write has come
    task automatic wait_drained();
        while (cmds_accepted != cmds_queued || expected_writes.size() != 0)
            @(posedge clk);
        sender_pauses++;
    endtask

    // Drive command words at the falling edge; advance only after a word is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_fired)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                cmd_valid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                cmd       <= cmd_backlog.pop_front();
                cmd_valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Stall the write side: random gaps, plus a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left = hold_left - 1;
        else if (holds_served < hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        else
            stall_left = pick_gap();
        wr_stall <= (hold_left > 0) || (stall_left > 0);
    end

    // Sample both handshakes at the rising edge: predict, check, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_fired <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                model_command(cmd);
                cmds_accepted++;
            end
            if (wr_valid && !wr_stall)
                check_write(wr);
            if ((cmd_valid && !cmd_stall) || (wr_valid && !wr_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Watchdog: no word moved for %0d cycles, %0d writes outstanding",
                             idle_cycles, expected_writes.size());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corner texels of both sheets, one black, one in the middle
        load_word(1'b0, 8'd0,   8'd0,   24'hFFFFFF);
        load_word(1'b1, 8'd255, 8'd255, 24'h000001);
        load_word(1'b0, 8'd255, 8'd255, BLACK);
        load_word(1'b1, 8'd0,   8'd0,   24'h800000);
        load_word(1'b0, 8'd128, 8'd64,  24'h00FF00);
        // Screen wrap below zero and at the far edge
        draw_word(1'b0, 8'd0,   8'd0,   6'd0,  6'd0,  7'd1,   7'd1,   9'd0,   9'd0,   9'd0);
        draw_word(1'b1, 8'd255, 8'd255, 6'd0,  6'd0,  7'd64,  7'd64,  9'd511, 9'd511, 9'd359);
        // Black texel gives no writes
        draw_word(1'b0, 8'd255, 8'd255, 6'd0,  6'd0,  7'd1,   7'd1,   9'd100, 9'd100, 9'd0);
        // Sheet coordinates wrap past the edge
        draw_word(1'b1, 8'd255, 8'd255, 6'd1,  6'd1,  7'd0,   7'd127, 9'd256, 9'd256, 9'd90);
        draw_word(1'b0, 8'd193, 8'd193, 6'd63, 6'd63, 7'd127, 7'd0,   9'd300, 9'd200, 9'd180);
        // Remaining quadrants and angles past a full turn
        draw_word(1'b1, 8'd0,   8'd0,   6'd0,  6'd0,  7'd2,   7'd2,   9'd10,  9'd500, 9'd270);
        draw_word(1'b1, 8'd0,   8'd0,   6'd0,  6'd0,  7'd3,   7'd5,   9'd40,  9'd60,  9'd360);
        draw_word(1'b1, 8'd0,   8'd0,   6'd0,  6'd0,  7'd7,   7'd9,   9'd480, 9'd20,  9'd511);
        draw_word(1'b0, 8'd65,  8'd64,  6'd63, 6'd0,  7'd64,  7'd1,   9'd128, 9'd384, 9'd45);
        draw_word(1'b0, 8'd128, 8'd1,   6'd0,  6'd63, 7'd1,   7'd64,  9'd384, 9'd128, 9'd135);
        draw_word(1'b0, 8'd128, 8'd64,  6'd0,  6'd0,  7'd0,   7'd0,   9'd200, 9'd300, 9'd225);
        // Overwrite a texel, then blank one that was visible
        load_word(1'b0, 8'd0,   8'd0,   24'h123456);
        draw_word(1'b0, 8'd0,   8'd0,   6'd0,  6'd0,  7'd4,   7'd4,   9'd511, 9'd0,   9'd315);
        load_word(1'b0, 8'd128, 8'd64,  BLACK);
        draw_word(1'b0, 8'd128, 8'd64,  6'd0,  6'd0,  7'd1,   7'd1,   9'd50,  9'd50,  9'd30);
        wait_drained();

        // Random traffic with gaps on both sides
        gen_random(cmds_queued + 150);
        wait_drained();

        // Hold off the write side while the sender keeps offering words;
        // a run of visible draws of one fresh texel is sure to fill the pipeline
        no_gaps = 1'b1;
        hold_requests++;
        load_word(1'b1, 8'd17, 8'd33, 24'h5A3C96);
        for (int i = 0; i < 24; i++)
            draw_word(1'b1, 8'd17, 8'd33, 6'd0, 6'd0, 7'd1, 7'd1, 9'd250, 9'd250, 9'd60);
        for (int i = 0; i < 3; i++)
            gen_sprite();
        wait_drained();

        // Back-to-back stretch with no idling on either side
        gen_random(cmds_queued + 120);
        wait_drained();

        // Random traffic with gaps again
        no_gaps = 1'b0;
        gen_random(450);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_writes.size() != 0)
            report($sformatf("%0d expected writes never arrived", expected_writes.size()));

        $display("Covered %0d loads and %0d draws (%0d blank), %0d screen writes checked",
                 loads_seen, draws_seen, blank_draws, writes_seen);
        $display("Included %0d sender pauses and a %0d-cycle write hold-off, %0d mismatches",
                 sender_pauses, LONG_HOLD, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rsb_pkg.sv
hdl/rsb_front.sv
hdl/rsb_rotate.sv
hdl/rsb_expand.sv
hdl/rotated_sprite_blit.sv
tb/tb_top.sv
